>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL files; the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/i2crf_pkg.sv
// Shared constants and types for the I2C register file target.
package i2crf_pkg;

    localparam int REG_COUNT = 32;
    localparam int RF_AW     = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int CMD_W     = 3;
    localparam int BYTE_W    = 8;
    localparam int TAW       = BYTE_W + 1;

    localparam logic [BYTE_W-1:0] FILL_BYTE = 8'h55;

    localparam logic [CMD_W-1:0] EV_WR_MATCH = 3'd0;
    localparam logic [CMD_W-1:0] EV_RX_BYTE  = 3'd1;
    localparam logic [CMD_W-1:0] EV_RD_MATCH = 3'd2;
    localparam logic [CMD_W-1:0] EV_TX_ACKED = 3'd3;
    localparam logic [CMD_W-1:0] EV_END      = 3'd4;

    typedef struct packed {
        logic capture;
        logic execute;
    } dp_ctrl_t;

endpackage

>>> hw/rtl/i2crf_ctrl.sv
// Controller: sequences capture, execute and result transfer for one item.
module i2crf_ctrl
    import i2crf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output dp_ctrl_t dp_ctrl
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_OUT
    } state_t;

    state_t state_reg;
    logic   s_tready_reg;
    logic   m_tvalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            s_tready_reg <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        state_reg    <= ST_EXEC;
                        s_tready_reg <= 1'b0;
                    end
                end
                ST_EXEC:
                begin
                    state_reg    <= ST_OUT;
                    m_tvalid_reg <= 1'b1;
                end
                ST_OUT:
                begin
                    if (m_tready)
                    begin
                        state_reg    <= ST_IDLE;
                        m_tvalid_reg <= 1'b0;
                        s_tready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg    <= ST_IDLE;
                    s_tready_reg <= 1'b1;
                    m_tvalid_reg <= 1'b0;
                end
            endcase
        end
    end

    assign s_tready        = s_tready_reg;
    assign m_tvalid        = m_tvalid_reg;
    assign dp_ctrl.capture = s_tvalid && s_tready_reg;
    assign dp_ctrl.execute = (state_reg == ST_EXEC);

endmodule

>>> hw/rtl/i2crf_datapath.sv
// Datapath: pointer, byte index, register file and result register.
module i2crf_datapath
    import i2crf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  dp_ctrl_t          dp_ctrl,
    input  logic [CMD_W-1:0]  cmd,
    input  logic [BYTE_W-1:0] rx_byte,
    output logic [BYTE_W-1:0] tx_byte,
    output logic              tx_valid
);

    logic [CMD_W-1:0]  cmd_reg;
    logic [BYTE_W-1:0] rx_reg;
    logic [BYTE_W-1:0] ptr_reg;
    logic [BYTE_W-1:0] idx_reg;
    logic [BYTE_W-1:0] rf_reg [REG_COUNT];
    logic [BYTE_W-1:0] tx_byte_reg;
    logic              tx_valid_reg;

    logic [BYTE_W-1:0] idx_inc;
    logic [TAW-1:0]    wr_addr;
    logic [TAW-1:0]    rd_addr;
    logic              wr_hit;
    logic              rd_hit;
    logic [BYTE_W-1:0] rd_data;

    assign idx_inc = idx_reg + 8'd1;
    assign wr_addr = {1'b0, ptr_reg} + {1'b0, idx_reg} - 9'd1;
    assign rd_addr = (cmd_reg == EV_RD_MATCH) ? {1'b0, ptr_reg}
                                              : {1'b0, ptr_reg} + {1'b0, idx_inc};
    assign wr_hit  = (wr_addr < TAW'(REG_COUNT));
    assign rd_hit  = (rd_addr < TAW'(REG_COUNT));
    assign rd_data = rd_hit ? rf_reg[rd_addr[RF_AW-1:0]] : FILL_BYTE;

    always_ff @(posedge clk)
    begin
        if (dp_ctrl.capture)
        begin
            cmd_reg <= cmd;
            rx_reg  <= rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
            idx_reg <= '0;
            for (int i = 0; i < REG_COUNT; i++)
            begin
                rf_reg[i] <= '0;
            end
        end
        else if (dp_ctrl.execute)
        begin
            case (cmd_reg)
                EV_RX_BYTE:
                begin
                    if (idx_reg == '0)
                    begin
                        ptr_reg <= rx_reg;
                    end
                    else if (wr_hit)
                    begin
                        rf_reg[wr_addr[RF_AW-1:0]] <= rx_reg;
                    end
                    idx_reg <= idx_inc;
                end
                EV_RD_MATCH, EV_END:
                begin
                    idx_reg <= '0;
                end
                EV_TX_ACKED:
                begin
                    idx_reg <= idx_inc;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_ctrl.execute)
        begin
            case (cmd_reg)
                EV_RD_MATCH, EV_TX_ACKED:
                begin
                    tx_byte_reg  <= rd_data;
                    tx_valid_reg <= 1'b1;
                end
                default:
                begin
                    tx_byte_reg  <= '0;
                    tx_valid_reg <= 1'b0;
                end
            endcase
        end
    end

    assign tx_byte  = tx_byte_reg;
    assign tx_valid = tx_valid_reg;

endmodule

>>> hw/rtl/i2c_register_file_target_top.sv
// The result is valid once the controller has passed through its execute
// and output states after the input transfer; the controller's capture,
// execute and output sequence keeps one item in flight at a time.
// Reset (async, active low) clears pointer, byte index and all register file entries.
`include "assert_macros.svh"
// Top level of the I2C register file target.
module i2c_register_file_target_top
    import i2crf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [2:0] cmd, [10:3] rx_byte, [15:11] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] tx_byte
    output logic [0:0]  m_tuser    // [0] tx_valid
);

    dp_ctrl_t dp_ctrl;

    i2crf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .dp_ctrl  (dp_ctrl)
    );

    i2crf_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .dp_ctrl  (dp_ctrl),
        .cmd      (s_tdata[2:0]),
        .rx_byte  (s_tdata[10:3]),
        .tx_byte  (m_tdata),
        .tx_valid (m_tuser[0])
    );

    `ASSERT_SAME(a_one_in_flight, m_tvalid, !s_tready)
    `ASSERT_NEXT(a_exec_after_accept, s_tvalid && s_tready, !s_tready && !m_tvalid)
    `ASSERT_SAME(a_result_two_later, s_tvalid && s_tready, ##2 m_tvalid)
    `ASSERT_SAME(a_read_gives_byte, s_tvalid && s_tready && s_tdata[2:0] == EV_RD_MATCH,
                 ##2 m_tuser[0])
    `ASSERT_SAME(a_no_byte_zero, m_tvalid && !m_tuser[0], m_tdata == 8'h00)

endmodule
